/* rtl/s20_pkg.sv */
// Shared types, constants and round functions for the Salsa20 stream cipher block.
// No dependencies; used by every module in this folder.
`timescale 1ns / 1ps
`default_nettype none

package s20_pkg;

   localparam int ROUND_COUNT_DEFAULT = 20;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] CSR_KEY_0 = 3'd0;
   localparam logic [2:0] CSR_KEY_1 = 3'd1;
   localparam logic [2:0] CSR_KEY_2 = 3'd2;
   localparam logic [2:0] CSR_KEY_3 = 3'd3;
   localparam logic [2:0] CSR_NONCE = 3'd4;
   localparam logic [2:0] CSR_START = 3'd5;

   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   typedef logic [15:0][31:0] state_type;
   typedef logic [3:0][31:0] quad_type;

   // One queued data word with its keystream coordinates.
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [57:0] block;
      logic [5:0]  offset;
   } entry_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   function automatic quad_type quarter(input quad_type q);
      quad_type r;
      r = q;
      r[1] = r[1] ^ rotl(r[0] + r[3], 7);
      r[2] = r[2] ^ rotl(r[1] + r[0], 9);
      r[3] = r[3] ^ rotl(r[2] + r[1], 13);
      r[0] = r[0] ^ rotl(r[3] + r[2], 18);
      return r;
   endfunction

   // Column round when is_col is set, row round otherwise.
   function automatic state_type round_fn(input state_type s, input logic is_col);
      state_type r;
      quad_type  q0;
      quad_type  q1;
      quad_type  q2;
      quad_type  q3;
      r = s;
      if (is_col) begin
         q0 = quarter({s[12], s[8],  s[4],  s[0]});
         q1 = quarter({s[1],  s[13], s[9],  s[5]});
         q2 = quarter({s[6],  s[2],  s[14], s[10]});
         q3 = quarter({s[11], s[7],  s[3],  s[15]});
         {r[12], r[8],  r[4],  r[0]}  = q0;
         {r[1],  r[13], r[9],  r[5]}  = q1;
         {r[6],  r[2],  r[14], r[10]} = q2;
         {r[11], r[7],  r[3],  r[15]} = q3;
      end else begin
         q0 = quarter({s[3],  s[2],  s[1],  s[0]});
         q1 = quarter({s[4],  s[7],  s[6],  s[5]});
         q2 = quarter({s[9],  s[8],  s[11], s[10]});
         q3 = quarter({s[14], s[13], s[12], s[15]});
         {r[3],  r[2],  r[1],  r[0]}  = q0;
         {r[4],  r[7],  r[6],  r[5]}  = q1;
         {r[9],  r[8],  r[11], r[10]} = q2;
         {r[14], r[13], r[12], r[15]} = q3;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/salsa20_stream_cipher_top.sv */
// Top level of the Salsa20 stream cipher: configuration registers, front end
// and back end. Depends on s20_pkg, s20_front and s20_back.
`timescale 1ns / 1ps
`default_nettype none

// Salsa20 stream cipher with a 256-bit key and 64-bit nonce, one byte per word.
// Each request word is XORed with the keystream byte at the current 64-bit
// byte position; tuser set on a word reloads the position from the start
// register first, and tlast is passed through to the response. Words inside
// one 64-byte keystream block flow at one word per cycle while the response
// side is ready, each passing the queue and the output register. When a word
// falls in a block that is not held, the round engine computes it: it loads
// the block state, runs one column or row round per cycle and then adds the
// input state. On a block miss the word waits at the queue head until the
// block is done, with an odd round count rounded up to whole double rounds.
// The first word after reset or after a key or nonce write always misses.
// The front end keeps accepting words into its four-entry queue meanwhile.
// Writing a key or nonce register drops the held block. Registers must only
// be written while the block is idle.
module salsa20_stream_cipher_top #(
   parameter int ROUND_COUNT = s20_pkg::ROUND_COUNT_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // data_byte
   input  wire         req_tuser,   // first_of_message
   input  wire         req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // last_out
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [63:0] csr_wdata
);

   logic [255:0]       key_ff;
   logic [63:0]        nonce_ff, start_ff;
   logic               invalidate;
   logic               pop, head_valid;
   s20_pkg::entry_type head;

   // A key or nonce write makes the held keystream block stale.
   assign invalidate = csr_we && (csr_index <= s20_pkg::CSR_NONCE);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         nonce_ff <= '0;
         start_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            s20_pkg::CSR_KEY_0: key_ff[63:0]    <= csr_wdata;
            s20_pkg::CSR_KEY_1: key_ff[127:64]  <= csr_wdata;
            s20_pkg::CSR_KEY_2: key_ff[191:128] <= csr_wdata;
            s20_pkg::CSR_KEY_3: key_ff[255:192] <= csr_wdata;
            s20_pkg::CSR_NONCE: nonce_ff        <= csr_wdata;
            s20_pkg::CSR_START: start_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   s20_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_data        (req_tdata),
      .in_first       (req_tuser),
      .in_last        (req_tlast),
      .start_position (start_ff),
      .pop            (pop),
      .head           (head),
      .head_valid     (head_valid)
   );

   s20_back #(
      .ROUND_COUNT (ROUND_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .key        (key_ff),
      .nonce      (nonce_ff),
      .invalidate (invalidate),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

/* rtl/s20_fifo.sv */
// Short queue of entries between the front and the back of the cipher.
// Depends on s20_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module s20_fifo #(
   parameter int DEPTH = s20_pkg::QUEUE_DEPTH
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  s20_pkg::entry_type  push_data,
   output logic                full,
   input  wire                 pop,
   output s20_pkg::entry_type  head,
   output logic                not_empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   s20_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]        cnt_ff, cnt_in;

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/s20_front.sv */
// Front end: accepts data words, tracks the byte position and queues each word
// with its block number and offset. Depends on s20_pkg and s20_fifo.
`timescale 1ns / 1ps
`default_nettype none

module s20_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  wire  [7:0]          in_data,
   input  wire                 in_first,
   input  wire                 in_last,
   input  wire  [63:0]         start_position,
   input  wire                 pop,
   output s20_pkg::entry_type  head,
   output logic                head_valid
);

   logic               full;
   logic               push;
   logic [63:0]        pos_ff, pos_in, cur_pos;
   s20_pkg::entry_type entry;

   assign in_ready = !full;
   assign push     = in_valid && !full;
   assign cur_pos  = in_first ? start_position : pos_ff;
   assign pos_in   = push ? cur_pos + 64'd1 : pos_ff;

   always_comb begin
      entry.data   = in_data;
      entry.last   = in_last;
      entry.block  = cur_pos[63:6];
      entry.offset = cur_pos[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= '0;
      else pos_ff <= pos_in;
   end

   s20_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .not_empty (head_valid)
   );

endmodule

`default_nettype wire

/* rtl/s20_back.sv */
// Back end: holds one keystream block, runs the round engine on a block miss
// and XORs queued words into the output register. Depends on s20_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s20_back #(
   parameter int ROUND_COUNT = s20_pkg::ROUND_COUNT_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  s20_pkg::entry_type  head,
   input  wire                 head_valid,
   output logic                pop,
   input  wire  [255:0]        key,
   input  wire  [63:0]         nonce,
   input  wire                 invalidate,
   output logic                out_valid,
   input  wire                 out_ready,
   output logic [7:0]          out_data,
   output logic                out_last
);

   localparam int NR = ((ROUND_COUNT + 1) / 2) * 2;
   localparam int CW = $clog2(NR + 1);

   s20_pkg::state_type init_state;
   s20_pkg::state_type work_ff, ks_ff;
   logic               busy_ff, ks_valid_ff;
   logic [57:0]        blk_ff;
   logic [CW-1:0]      cnt_ff;
   logic               hit, out_free;
   logic [31:0]        word;
   logic [7:0]         ks_byte;
   logic [63:0]        blk64;

   assign blk64 = {6'd0, head.block};

   always_comb begin
      init_state[0]  = s20_pkg::SIGMA_0;
      init_state[1]  = key[31:0];
      init_state[2]  = key[63:32];
      init_state[3]  = key[95:64];
      init_state[4]  = key[127:96];
      init_state[5]  = s20_pkg::SIGMA_1;
      init_state[6]  = nonce[31:0];
      init_state[7]  = nonce[63:32];
      init_state[8]  = blk64[31:0];
      init_state[9]  = blk64[63:32];
      init_state[10] = s20_pkg::SIGMA_2;
      init_state[11] = key[159:128];
      init_state[12] = key[191:160];
      init_state[13] = key[223:192];
      init_state[14] = key[255:224];
      init_state[15] = s20_pkg::SIGMA_3;
   end

   assign hit      = ks_valid_ff && (blk_ff == head.block);
   assign out_free = !out_valid || out_ready;
   assign pop      = head_valid && hit && out_free && !busy_ff;
   assign word     = ks_ff[head.offset[5:2]];
   assign ks_byte  = 8'(word >> {head.offset[1:0], 3'b000});

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data <= head.data ^ ks_byte;
         out_last <= head.last;
      end
      if (!busy_ff) begin
         work_ff <= init_state;
      end else if (cnt_ff != CW'(NR)) begin
         work_ff <= s20_pkg::round_fn(work_ff, !cnt_ff[0]);
      end
      if (busy_ff && cnt_ff == CW'(NR)) begin
         for (int i = 0; i < 16; i++) ks_ff[i] <= work_ff[i] + init_state[i];
         blk_ff <= head.block;
      end
      if (reset) begin
         out_valid   <= 1'b0;
         busy_ff     <= 1'b0;
         ks_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         if (pop) out_valid <= 1'b1;
         else if (out_ready) out_valid <= 1'b0;
         if (!busy_ff) begin
            cnt_ff <= '0;
            if (head_valid && !hit && !invalidate) busy_ff <= 1'b1;
         end else if (cnt_ff == CW'(NR)) begin
            busy_ff     <= 1'b0;
            ks_valid_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (invalidate) ks_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire
